@@ sv/rtlpm_pkg.sv @@
`default_nettype none

package rtlpm_pkg;

   // default table depth
   localparam int ENTRIES_DEF = 16;

   // width of the slot field in a response
   localparam int SLOT_W = 4;

   // request operation codes
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // decoded command kinds
   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;
   localparam logic [1:0] KIND_NOP    = 2'd3;

   // response status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_NO_ROUTE = 2'd2;

   // classified command, front to back
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] addr;
      logic [31:0] network;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [3:0]  iface;
      logic [7:0]  metric;
      logic [5:0]  plen;
   } cmd_type;

   // one route table entry, prefix length kept precomputed
   typedef struct packed {
      logic [31:0] network;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [3:0]  iface;
      logic [7:0]  metric;
      logic [5:0]  plen;
   } entry_type;

   // response fields
   typedef struct packed {
      logic [1:0]        status;
      logic [31:0]       gateway;
      logic [3:0]        iface;
      logic [7:0]        metric;
      logic [5:0]        plen;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   // number of set bits in a mask, summed as a balanced tree
   function automatic logic [5:0] popcount32(input logic [31:0] v);
      logic [1:0] s2  [16];
      logic [2:0] s4  [8];
      logic [3:0] s8  [4];
      logic [4:0] s16 [2];
      for (int i = 0; i < 16; i++) begin
         s2[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
      end
      for (int i = 0; i < 8; i++) begin
         s4[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         s8[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         s16[i] = {1'b0, s8[2*i]} + {1'b0, s8[2*i+1]};
      end
      return {1'b0, s16[0]} + {1'b0, s16[1]};
   endfunction

endpackage

`default_nettype wire

@@ sv/rtlpm_front.sv @@
`default_nettype none

module rtlpm_front
   import rtlpm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request side
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [1:0]  in_op,
   input  wire logic [31:0] in_lookup_addr,
   input  wire logic [31:0] in_route_network,
   input  wire logic [31:0] in_route_mask,
   input  wire logic [31:0] in_route_gateway,
   input  wire logic [3:0]  in_route_iface,
   input  wire logic [7:0]  in_route_metric,
   // queue head toward the back end
   output logic             q_valid,
   output cmd_type          q_cmd,
   input  wire logic        q_pop
);

   cmd_type    fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cmd_new;
   logic       push;
   logic       pop;

   // classify the request
   always_comb begin
      cmd_new.addr    = in_lookup_addr;
      cmd_new.network = in_route_network;
      cmd_new.mask    = in_route_mask;
      cmd_new.gateway = in_route_gateway;
      cmd_new.iface   = in_route_iface;
      cmd_new.metric  = in_route_metric;
      cmd_new.plen    = popcount32(in_route_mask);
      unique case (in_op)
         OP_LOOKUP: cmd_new.kind = KIND_LOOKUP;
         OP_ADD:    cmd_new.kind = KIND_ADD;
         OP_DELETE: cmd_new.kind = KIND_DELETE;
         default:   cmd_new.kind = KIND_NOP;
      endcase
   end

   // two-entry queue
   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_cmd    = fifo_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

@@ sv/rtlpm_back.sv @@
`default_nettype none

module rtlpm_back
   import rtlpm_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   // queue head from the front end
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   // response register
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(ENTRIES);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic               found_ff, found_in;
   logic [5:0]         best_len_ff, best_len_in;
   logic [7:0]         best_metric_ff, best_metric_in;
   logic [31:0]        best_gw_ff, best_gw_in;
   logic [3:0]         best_iface_ff, best_iface_in;
   logic [IDX_W-1:0]   best_slot_ff, best_slot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // entry memory, one write and one registered read port
   entry_type          entry_ff [ENTRIES];
   entry_type          rd_q_ff;
   entry_type          wr_data;
   logic               wr_en;

   logic [IDX_W-1:0]   scan_idx;
   logic               scan_live;
   logic               pend_ok;
   logic               lk_hit;
   logic               lk_better;
   logic               del_hit;
   logic               out_free;
   logic [SLOT_W+IDX_W-1:0] slot_ext;

   assign scan_idx  = scan_ff[IDX_W-1:0];
   assign scan_live = (scan_ff != SCAN_END);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign slot_ext  = {{SLOT_W{1'b0}}, best_slot_ff};

   // compare the entry read in the previous cycle
   assign pend_ok   = pend_ff && valid_ff[pend_idx_ff];
   assign lk_hit    = pend_ok && ((cmd_ff.addr & rd_q_ff.mask) == rd_q_ff.network);
   assign lk_better = !found_ff || (rd_q_ff.plen > best_len_ff) ||
                      ((rd_q_ff.plen == best_len_ff) && (rd_q_ff.metric < best_metric_ff));
   assign del_hit   = pend_ok && (rd_q_ff.network == cmd_ff.network) &&
                      (rd_q_ff.mask == cmd_ff.mask);

   always_comb begin
      wr_data.network = cmd_ff.network;
      wr_data.mask    = cmd_ff.mask;
      wr_data.gateway = cmd_ff.gateway;
      wr_data.iface   = cmd_ff.iface;
      wr_data.metric  = cmd_ff.metric;
      wr_data.plen    = cmd_ff.plen;
   end

   // sequencer: one slot per cycle
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      scan_in        = scan_ff;
      pend_in        = pend_ff;
      pend_idx_in    = pend_idx_ff;
      valid_in       = valid_ff;
      found_in       = found_ff;
      best_len_in    = best_len_ff;
      best_metric_in = best_metric_ff;
      best_gw_in     = best_gw_ff;
      best_iface_in  = best_iface_ff;
      best_slot_in   = best_slot_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_in         = rsp_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               scan_in  = '0;
               pend_in  = 1'b0;
               found_in = 1'b0;
               state_in = (q_cmd.kind == KIND_NOP) ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            // issue the read for the next slot
            pend_in     = scan_live;
            pend_idx_in = scan_idx;
            if (scan_live) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            unique case (cmd_ff.kind)
               KIND_ADD: begin
                  if (!scan_live) begin
                     state_in = S_DONE;
                  end else if (!valid_ff[scan_idx]) begin
                     wr_en              = 1'b1;
                     valid_in[scan_idx] = 1'b1;
                     found_in           = 1'b1;
                     best_slot_in       = scan_idx;
                     state_in           = S_DONE;
                  end
               end
               KIND_DELETE: begin
                  if (del_hit) begin
                     valid_in[pend_idx_ff] = 1'b0;
                     state_in              = S_DONE;
                  end else if (!pend_ff && !scan_live) begin
                     state_in = S_DONE;
                  end
               end
               default: begin
                  if (lk_hit && lk_better) begin
                     found_in       = 1'b1;
                     best_len_in    = rd_q_ff.plen;
                     best_metric_in = rd_q_ff.metric;
                     best_gw_in     = rd_q_ff.gateway;
                     best_iface_in  = rd_q_ff.iface;
                     best_slot_in   = pend_idx_ff;
                  end
                  if (!pend_ff && !scan_live) begin
                     state_in = S_DONE;
                  end
               end
            endcase
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (cmd_ff.kind == KIND_LOOKUP) begin
                  if (found_ff) begin
                     rsp_in.status  = STATUS_OK;
                     rsp_in.gateway = best_gw_ff;
                     rsp_in.iface   = best_iface_ff;
                     rsp_in.metric  = best_metric_ff;
                     rsp_in.plen    = best_len_ff;
                     rsp_in.slot    = slot_ext[SLOT_W-1:0];
                  end else begin
                     rsp_in.status = STATUS_NO_ROUTE;
                  end
               end else if (cmd_ff.kind == KIND_ADD) begin
                  if (found_ff) begin
                     rsp_in.slot = slot_ext[SLOT_W-1:0];
                  end else begin
                     rsp_in.status = STATUS_FULL;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      pend_idx_ff    <= pend_idx_in;
      best_len_ff    <= best_len_in;
      best_metric_ff <= best_metric_in;
      best_gw_ff     <= best_gw_in;
      best_iface_ff  <= best_iface_in;
      best_slot_ff   <= best_slot_in;
      rsp_ff         <= rsp_in;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[scan_idx] <= wr_data;
      end
      rd_q_ff <= entry_ff[scan_idx];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

@@ sv/route_table_longest_prefix.sv @@
// Route table with longest-prefix lookup, one request at a time in the back end.
// Each request is scanned one slot per cycle: a lookup or an unmatched delete scans
// every slot, a matching delete stops at its slot, an add stops at the first free slot,
// an add to a full table scans every slot, and an unused op code skips the scan. The back
// end takes the next request only when done with the last; a stalled response holds the back end, the queue takes two.
// Reset: synchronous; all valid bits clear at once, no clearing pass.
`default_nettype none

module route_table_longest_prefix
   import rtlpm_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [31:0] lookup_addr, [63:32] route_network, [95:64] route_mask,
   // [127:96] route_gateway, [131:128] route_iface, [139:132] route_metric, rest zero
   input  wire logic [143:0] req_tdata,
   // [1:0] op
   input  wire logic [1:0]   req_tuser,
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] hit_gateway, [35:32] hit_iface, [43:36] hit_metric,
   // [49:44] hit_prefix_len, [53:50] hit_slot, rest zero
   output logic [55:0]       rsp_tdata,
   // [1:0] status
   output logic [1:0]        rsp_tuser
);

   logic    q_valid;
   cmd_type q_cmd;
   logic    q_pop;
   rsp_type rsp;

   rtlpm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .in_op            (req_tuser),
      .in_lookup_addr   (req_tdata[31:0]),
      .in_route_network (req_tdata[63:32]),
      .in_route_mask    (req_tdata[95:64]),
      .in_route_gateway (req_tdata[127:96]),
      .in_route_iface   (req_tdata[131:128]),
      .in_route_metric  (req_tdata[139:132]),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop)
   );

   rtlpm_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // pack response fields
   assign rsp_tdata = {2'b00, rsp.slot, rsp.plen, rsp.metric, rsp.iface, rsp.gateway};
   assign rsp_tuser = rsp.status;

endmodule

`default_nettype wire
